// ----- sv/prfe_pkg.sv -----
// ----------------------------------------------------------------------------
// prfe_pkg
// Shared types, codes and defaults for the planar rectangle fill engine.
// ----------------------------------------------------------------------------
package prfe_pkg;

    localparam int PLANE_BYTES_DEF = 16384;
    localparam int NUM_PLANES_DEF  = 4;
    localparam int CFG_W           = 11;
    localparam int COLOR_W         = 4;

    localparam logic [1:0] CMD_FILL  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    // Classified job from the front part: byte span and rows to walk.
    typedef struct packed {
        logic       walk;
        logic       rd;
        logic [1:0] status;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [2:0] lo;
        logic [2:0] hi;
        logic [10:0] row0;
        logic [10:0] rows;
        logic [8:0] pitch;
        logic [COLOR_W-1:0] color;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    function automatic logic [7:0] edge_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] a;
        logic [7:0] b;
        a = BYTE_ONES >> lo;
        b = BYTE_ONES << (3'd7 - hi);
        return a & b;
    endfunction

endpackage

// ----- sv/prfe_ram.sv -----
// ----------------------------------------------------------------------------
// prfe_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module prfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- sv/prfe_front.sv -----
// ----------------------------------------------------------------------------
// prfe_front
// Accept a command, clip it to the surface and register one job.
// ----------------------------------------------------------------------------
module prfe_front
    import prfe_pkg::*;
#(
    parameter int PLANE_BYTES = PLANE_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [11:0] pos_x,
    input  logic signed [11:0] pos_y,
    input  logic signed [12:0] rect_width,
    input  logic signed [12:0] rect_height,
    input  logic [COLOR_W-1:0] color,
    input  logic [CFG_W-1:0]   sw,
    input  logic [CFG_W-1:0]   sh,
    output logic               job_valid,
    input  logic               job_ready,
    output job_t               job
);

    logic        full_reg;
    logic        full_next;
    job_t        job_reg;
    job_t        job_next;
    logic [8:0]  pitch;
    logic [18:0] area;
    logic signed [14:0] x1, y1, x2, y2, sws, shs;

    assign pitch = 9'((12'(sw) + 12'd7) >> 3);
    assign area  = 19'(pitch) * 19'(sh);
    assign sws   = 15'(sw);
    assign shs   = 15'(sh);

    always_comb
    begin
        x1 = 15'(pos_x);
        y1 = 15'(pos_y);
        if (x1 < 0) x1 = 15'sd0;
        if (y1 < 0) y1 = 15'sd0;
        x2 = 15'(pos_x) + 15'(rect_width) - 15'sd1;
        y2 = 15'(pos_y) + 15'(rect_height) - 15'sd1;
        if (x2 >= sws) x2 = sws - 15'sd1;
        if (y2 >= shs) y2 = shs - 15'sd1;

        job_next = '0;
        job_next.pitch = pitch;
        job_next.color = color;
        if (area > 19'(PLANE_BYTES))
        begin
            job_next.status = ST_TOO_BIG;
        end
        else
        begin
            unique case (cmd)
                CMD_FILL:
                begin
                    if (rect_width <= 0 || rect_height <= 0 || x1 > x2 || y1 > y2)
                        job_next.status = ST_EMPTY;
                    else
                    begin
                        job_next.walk = 1'b1;
                        job_next.b1   = 8'(x1 >>> 3);
                        job_next.b2   = 8'(x2 >>> 3);
                        job_next.lo   = 3'(x1);
                        job_next.hi   = 3'(x2);
                        job_next.row0 = 11'(y1);
                        job_next.rows = 11'(y2 - y1 + 15'sd1);
                    end
                end
                CMD_SET, CMD_READ:
                begin
                    if (pos_x < 0 || 15'(pos_x) >= sws || pos_y < 0 || 15'(pos_y) >= shs)
                        job_next.status = ST_EMPTY;
                    else
                    begin
                        job_next.walk = 1'b1;
                        job_next.rd   = (cmd == CMD_READ);
                        job_next.b1   = 8'(pos_x >>> 3);
                        job_next.b2   = 8'(pos_x >>> 3);
                        job_next.lo   = 3'(pos_x);
                        job_next.hi   = 3'(pos_x);
                        job_next.row0 = 11'(pos_y);
                        job_next.rows = 11'd1;
                    end
                end
                CMD_CLEAR:
                begin
                    if (pitch != 9'd0 && sh != '0)
                    begin
                        job_next.walk = 1'b1;
                        job_next.b1   = 8'd0;
                        job_next.b2   = 8'(pitch - 9'd1);
                        job_next.lo   = 3'd0;
                        job_next.hi   = 3'd7;
                        job_next.rows = sh;
                    end
                end
                default: job_next.status = ST_EMPTY;
            endcase
        end
    end

    assign in_ready  = !full_reg || job_ready;
    assign job_valid = full_reg;
    assign job       = job_reg;

    always_comb
    begin
        full_next = full_reg;
        if (in_valid && in_ready)
            full_next = 1'b1;
        else if (job_ready)
            full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            job_reg <= job_next;
    end

endmodule

// ----- sv/prfe_back.sv -----
// ----------------------------------------------------------------------------
// prfe_back
// Walk rows and byte columns of a job, read-modify-write every plane (a read
// job only reads); after reset, sweep all planes to zero.
module prfe_back
    import prfe_pkg::*;
#(
    parameter int PLANE_BYTES = PLANE_BYTES_DEF,
    parameter int NUM_PLANES  = NUM_PLANES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  job_t               job,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [COLOR_W-1:0] pixel_color
);

    localparam int AW = $clog2(PLANE_BYTES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLR   = 5'b00010,
        S_READ  = 5'b00100,
        S_WRITE = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    job_t               job_reg;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [7:0]         col_reg, col_next;
    logic [10:0]        row_reg, row_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [1:0]         st_reg;
    logic [COLOR_W-1:0] pix_reg;
    logic               load;
    logic [AW-1:0]      addr;
    logic [7:0]         mask;
    logic               we;
    logic [7:0]         rdata [NUM_PLANES];
    logic [COLOR_W-1:0] rd_color;

    assign addr = (state_reg == S_CLR) ? clr_reg : AW'(base_reg + AW'(col_reg));
    assign mask = edge_mask((col_reg == job_reg.b1) ? job_reg.lo : 3'd0,
                            (col_reg == job_reg.b2) ? job_reg.hi : 3'd7);
    assign we   = (state_reg == S_CLR) || (state_reg == S_WRITE && !job_reg.rd);

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        logic [7:0] wd;
        logic       cb;
        if (p < COLOR_W)
            assign cb = job_reg.color[p];
        else
            assign cb = 1'b0;
        assign wd = (state_reg == S_CLR) ? 8'h00 :
                    (cb ? (rdata[p] | mask) : (rdata[p] & ~mask));
        prfe_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_ram (
            .clk   (clk),
            .we    (we),
            .addr  (addr),
            .wdata (wd),
            .rdata (rdata[p])
        );
    end

    always_comb
    begin
        rd_color = '0;
        for (int p = 0; p < NUM_PLANES && p < COLOR_W; p++)
            rd_color[p] = |(rdata[p] & mask);
    end

    assign job_ready   = (state_reg == S_IDLE);
    assign load        = job_valid && job_ready;
    assign out_valid   = (state_reg == S_OUT);
    assign status      = st_reg;
    assign pixel_color = pix_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        base_next  = base_reg;
        unique case (state_reg)
            S_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(PLANE_BYTES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (load)
                begin
                    col_next  = job.b1;
                    row_next  = 11'd0;
                    base_next = AW'(22'(job.row0) * 22'(job.pitch));
                    state_next = job.walk ? S_READ : S_OUT;
                end
            end
            S_READ: state_next = S_WRITE;
            S_WRITE:
            begin
                state_next = S_READ;
                if (col_reg == job_reg.b2)
                begin
                    col_next = job_reg.b1;
                    row_next = row_reg + 11'd1;
                    base_next = base_reg + AW'(job_reg.pitch);
                    if (row_reg + 11'd1 == job_reg.rows)
                        state_next = S_OUT;
                end
                else
                    col_next = col_reg + 8'd1;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        row_reg  <= row_next;
        base_reg <= base_next;
        if (load)
        begin
            job_reg <= job;
            st_reg  <= job.status;
            pix_reg <= '0;
        end
        if (state_reg == S_WRITE && job_reg.rd)
            pix_reg <= rd_color;
    end

endmodule

// ----- sv/planar_rect_fill_engine_core.sv -----
// ----------------------------------------------------------------------------
// planar_rect_fill_engine_core
// Four-plane 1-bpp surface store with fill, set, read and clear commands.
// ----------------------------------------------------------------------------
// Usage: write surface_width (index 0) and surface_height (index 1) on the
// cfg port while idle. Send one command item on in_valid/in_ready; exactly
// one result item (status, pixel_color) returns on out_valid/out_ready.
// A front stage clips the command into a byte-span job held in a one-entry
// queue; the back walks it through the plane RAMs byte by byte (read, then
// write of all planes at once). Clear walks pitch * height bytes.
// The front accepts the next item while the back still works or its result
// waits; when out_ready is low the result is held and the back stalls.
// After reset the planes are zeroed by a sweep of all PLANE_BYTES bytes; one
// item may be queued meanwhile but none is carried out until the sweep ends.
// Config writes are taken at any time.
// ----------------------------------------------------------------------------
module planar_rect_fill_engine_core
    import prfe_pkg::*;
#(
    parameter int PLANE_BYTES = PLANE_BYTES_DEF,
    parameter int NUM_PLANES  = NUM_PLANES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [11:0] pos_x,
    input  logic signed [11:0] pos_y,
    input  logic signed [12:0] rect_width,
    input  logic signed [12:0] rect_height,
    input  logic [COLOR_W-1:0] color,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [COLOR_W-1:0] pixel_color
);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             job_valid;
    logic             job_ready;
    job_t             job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(640);
            height_reg <= CFG_W'(200);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_WIDTH:  width_reg  <= cfg_data;
                CFG_IDX_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    prfe_front #(.PLANE_BYTES(PLANE_BYTES)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .cmd, .pos_x, .pos_y,
        .rect_width, .rect_height, .color,
        .sw (width_reg), .sh (height_reg),
        .job_valid, .job_ready, .job
    );

    prfe_back #(.PLANE_BYTES(PLANE_BYTES), .NUM_PLANES(NUM_PLANES)) u_back (
        .clk, .rst_n, .job_valid, .job_ready, .job,
        .out_valid, .out_ready, .status, .pixel_color
    );

`ifndef SYNTH
    a_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid && !job_ready |=> job_valid && $stable(job))
        else $error("queued job changed while stalled");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status code");
    a_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> pixel_color == '0)
        else $error("color on failed command");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the planar rectangle fill engine. A shadow copy of
// the four bit planes is painted for every accepted command to produce the
// expected status and pixel colour. Directed commands cover clipping, edge
// masks and out-of-range pixels. Random phases then run over many surface
// sizes, including empty and oversized ones, with random idling on both
// channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    import prfe_pkg::*;

    localparam int PLANE_SZ   = 16384;
    localparam int CYCLE_CAP  = 20000000;
    localparam int STALL_LEN  = 2500;

    typedef struct {
        logic [1:0]         op;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic signed [12:0] w;
        logic signed [12:0] h;
        logic [3:0]         col;
    } draw_cmd_t;

    typedef struct {
        logic [1:0] st;
        logic [3:0] pix;
    } draw_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = 1'b0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic signed [12:0] rect_width;
    logic signed [12:0] rect_height;
    logic [COLOR_W-1:0] color;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [COLOR_W-1:0] pixel_color;

    planar_rect_fill_engine_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .pos_x(pos_x), .pos_y(pos_y),
        .rect_width(rect_width), .rect_height(rect_height), .color(color),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .pixel_color(pixel_color)
    );

    logic [7:0]   shadow [4][PLANE_SZ];
    int           surf_w = 640;
    int           surf_h = 200;
    draw_cmd_t    cmd_q[$];
    draw_result_t result_q[$];
    draw_cmd_t    cur;
    int           idle_pct = 26;
    logic         hold_req = 1'b0;
    logic         hold_used;
    int           hold_cnt;
    int           cycles;
    int           errors = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void write_byte(int off, logic [7:0] m, logic [3:0] c);
        for (int p = 0; p < 4; p++) begin
            if (c[p])
                shadow[p][off] = shadow[p][off] | m;
            else
                shadow[p][off] = shadow[p][off] & ~m;
        end
    endfunction

    function automatic draw_result_t paint_surface(draw_cmd_t it);
        draw_result_t r;
        int pitch;
        int px;
        int py;
        int w;
        int h;
        int x2;
        int b1;
        int b2;
        int lo;
        int hi;
        int off;
        logic [7:0] m;
        pitch = (surf_w + 7) >> 3;
        px = it.x;
        py = it.y;
        w = it.w;
        h = it.h;
        r.st = ST_DONE;
        r.pix = '0;
        if (pitch * surf_h > PLANE_SZ) begin
            r.st = ST_TOO_BIG;
            return r;
        end
        case (it.op)
            CMD_FILL: begin
                if (w <= 0 || h <= 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    if (px < 0) begin w += px; px = 0; end
                    if (py < 0) begin h += py; py = 0; end
                    x2 = px + w - 1;
                    if (x2 >= surf_w) x2 = surf_w - 1;
                    if (py + h > surf_h) h = surf_h - py;
                    if (px > x2 || h <= 0) begin
                        r.st = ST_EMPTY;
                    end else begin
                        b1 = px >> 3;
                        b2 = x2 >> 3;
                        for (int row = py; row < py + h; row++) begin
                            for (int b = b1; b <= b2; b++) begin
                                lo = (b == b1) ? (px & 7) : 0;
                                hi = (b == b2) ? (x2 & 7) : 7;
                                m = (8'hFF >> lo) & (8'hFF << (7 - hi));
                                write_byte(row * pitch + b, m, it.col);
                            end
                        end
                    end
                end
            end
            CMD_SET, CMD_READ: begin
                if (px < 0 || px >= surf_w || py < 0 || py >= surf_h) begin
                    r.st = ST_EMPTY;
                end else begin
                    off = py * pitch + (px >> 3);
                    m = 8'h80 >> (px & 7);
                    if (it.op == CMD_SET)
                        write_byte(off, m, it.col);
                    else
                        for (int p = 0; p < 4; p++)
                            r.pix[p] = |(shadow[p][off] & m);
                end
            end
            default: begin
                for (int i = 0; i < pitch * surf_h; i++)
                    write_byte(i, 8'hFF, it.col);
            end
        endcase
        return r;
    endfunction

    // Driver: present queued items, hold until accepted.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            cmd         <= CMD_FILL;
            pos_x       <= '0;
            pos_y       <= '0;
            rect_width  <= '0;
            rect_height <= '0;
            color       <= '0;
        end else begin
            if (in_valid && in_ready)
                result_q.push_back(paint_surface(cur));
            if (!in_valid || in_ready) begin
                if (cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    cur = cmd_q.pop_front();
                    in_valid    <= 1'b1;
                    cmd         <= cur.op;
                    pos_x       <= cur.x;
                    pos_y       <= cur.y;
                    rect_width  <= cur.w;
                    rect_height <= cur.h;
                    color       <= cur.col;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result item with the oldest expectation.
    always @(posedge clk or negedge rst_n) begin
        draw_result_t exp_r;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_cnt  <= 0;
            hold_used <= 1'b0;
            cycles    <= 0;
        end else begin
            cycles <= cycles + 1;
            if (cycles > CYCLE_CAP) begin
                $display("%0t: timeout", $time);
                $display("Verification failed");
                $finish;
            end
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected item status=%0d pixel_color=%0d",
                             $time, status, pixel_color);
                    errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (status !== exp_r.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.st, status);
                        errors++;
                    end
                    if (pixel_color !== exp_r.pix) begin
                        $display("%0t: pixel_color expected %0d actual %0d",
                                 $time, exp_r.pix, pixel_color);
                        errors++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt  <= hold_cnt - 1;
                out_ready <= 1'b0;
            end else if (hold_req && !hold_used) begin
                hold_cnt  <= STALL_LEN;
                hold_used <= 1'b1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    task automatic add_cmd(int op, int x, int y, int w, int h, int c);
        draw_cmd_t it;
        it.op  = 2'(op);
        it.x   = 12'(x);
        it.y   = 12'(y);
        it.w   = 13'(w);
        it.h   = 13'(h);
        it.col = 4'(c);
        cmd_q.push_back(it);
    endtask

    task automatic add_random(int n);
        int r;
        int x;
        int y;
        logic [1:0] op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                add_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                r = $urandom_range(0, 99);
                op = (r < 35) ? CMD_FILL : (r < 66) ? CMD_SET :
                     (r < 97) ? CMD_READ : CMD_CLEAR;
                x = int'($urandom_range(0, surf_w + 15)) - 8;
                y = int'($urandom_range(0, surf_h + 15)) - 8;
                if (op == CMD_FILL && $urandom_range(0, 99) < 3)
                    add_cmd(op, x, y, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom);
                else
                    add_cmd(op, x, y, int'($urandom_range(0, 40)) - 2,
                            int'($urandom_range(0, 12)) - 1, $urandom);
                if (op == CMD_SET && $urandom_range(0, 1) == 1)
                    add_cmd(CMD_READ, x, y, 0, 0, 0);
            end
        end
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || in_valid || result_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_IDX_WIDTH)
            surf_w = val & 11'h7FF;
        else
            surf_h = val & 11'h7FF;
    endtask

    initial begin
        int geo_w[10] = '{640, 13, 1, 0, 37, 2047, 1024, 1024, 100, 2047};
        int geo_h[10] = '{200, 9, 1, 7, 0, 8, 128, 1024, 60, 2047};
        for (int p = 0; p < 4; p++)
            for (int i = 0; i < PLANE_SZ; i++)
                shadow[p][i] = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_cmd(CMD_READ, 639, 199, 0, 0, 0);
        add_cmd(CMD_FILL, -2048, -2048, 4095, 4095, 15);
        add_cmd(CMD_READ, 0, 0, 0, 0, 0);
        add_cmd(CMD_FILL, 3, 5, 10, 3, 5);
        add_cmd(CMD_READ, 3, 5, 0, 0, 0);
        add_cmd(CMD_READ, 2, 5, 0, 0, 0);
        add_cmd(CMD_FILL, 10, 10, 0, 5, 1);
        add_cmd(CMD_FILL, 10, 10, -4096, -4096, 1);
        add_cmd(CMD_FILL, 2047, 2047, 5, 5, 2);
        add_cmd(CMD_FILL, -20, 3, 10, 3, 2);
        add_cmd(CMD_FILL, 20, 20, 1, 1, 6);
        add_cmd(CMD_READ, 20, 20, 0, 0, 0);
        add_cmd(CMD_CLEAR, 0, 0, 0, 0, 9);
        add_cmd(CMD_SET, 0, 0, 0, 0, 10);
        add_cmd(CMD_READ, 0, 0, 0, 0, 0);
        add_cmd(CMD_SET, 7, 1, 0, 0, 3);
        add_cmd(CMD_READ, 7, 1, 0, 0, 0);
        add_cmd(CMD_SET, -1, 0, 0, 0, 3);
        add_cmd(CMD_SET, 640, 0, 0, 0, 3);
        add_cmd(CMD_SET, 0, 200, 0, 0, 3);
        add_cmd(CMD_READ, 0, -2048, 0, 0, 0);
        add_cmd(CMD_READ, 2047, 0, 0, 0, 0);
        add_cmd(CMD_FILL, 630, 195, 100, 100, 12);
        add_cmd(CMD_READ, 639, 199, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_IDX_WIDTH, geo_w[ph]);
            write_reg(CFG_IDX_HEIGHT, geo_h[ph]);
            if (ph == 2)
                idle_pct <= 0;
            else
                idle_pct <= 26;
            if (ph == 8)
                hold_req <= 1'b1;
            add_random(ph == 8 ? 65 : 45);
            drain();
        end

        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- planar_rect_fill_engine_core.f -----
sv/prfe_pkg.sv
sv/prfe_ram.sv
sv/prfe_front.sv
sv/prfe_back.sv
sv/planar_rect_fill_engine_core.sv
tb/tb_top.sv
